// ===== sv/tge_pkg.sv =====
// Shared types, codes and the coordinate helper for the tile grid edge extractor.
package tge_pkg;

  localparam int CoordBits = 15;
  localparam int IdOutBits = 16;

  localparam logic [CoordBits-1:0] CoordMax    = 15'h7FFF;
  localparam logic [6:0]           CellSizeMax = 7'd64;

  // Cell side codes
  localparam logic [1:0] SideNorth = 2'd0;
  localparam logic [1:0] SideEast  = 2'd1;
  localparam logic [1:0] SideSouth = 2'd2;
  localparam logic [1:0] SideWest  = 2'd3;

  // Result kinds
  localparam logic KindNew    = 1'b0;
  localparam logic KindExtend = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] RegGridWidth  = 2'd0;
  localparam logic [1:0] RegGridHeight = 2'd1;
  localparam logic [1:0] RegCellSize   = 2'd2;

  typedef struct packed {
    logic                 kind;
    logic [1:0]           side;
    logic [IdOutBits-1:0] edge_index;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
  } result_t;

  // n * cell_size, cell size clamped to 64, result saturated to 15 bits
  function automatic logic [CoordBits-1:0] coord(input logic [12:0] n, input logic [6:0] cs);
    logic [6:0]  cs_used;
    logic [19:0] prod;
    cs_used = (cs > CellSizeMax) ? CellSizeMax : cs;
    prod    = 20'(n) * 20'(cs_used);
    coord   = (prod > 20'(CoordMax)) ? CoordMax : prod[CoordBits-1:0];
  endfunction

endpackage

// ===== sv/tge_cell_if.sv =====
// Cell input channel: valid/ready plus occupancy bits of a cell and its neighbors.
interface tge_cell_if;
  logic valid;
  logic ready;
  logic frame_start;
  logic here_on;
  logic east_on;
  logic south_on;

  modport source (output valid, output frame_start, output here_on, output east_on,
                  output south_on, input ready);
  modport sink   (input valid, input frame_start, input here_on, input east_on,
                  input south_on, output ready);
endinterface

// ===== sv/tge_edge_if.sv =====
// Edge result channel: valid/ready plus one edge update.
interface tge_edge_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [1:0]                          side;
  logic [tge_pkg::IdOutBits-1:0]       edge_index;
  logic [tge_pkg::CoordBits-1:0]       start_x;
  logic [tge_pkg::CoordBits-1:0]       start_y;
  logic [tge_pkg::CoordBits-1:0]       end_x;
  logic [tge_pkg::CoordBits-1:0]       end_y;
  logic                                overflow;
  logic                                last;

  modport source (output valid, output kind, output side, output edge_index, output start_x,
                  output start_y, output end_x, output end_y, output overflow, output last,
                  input ready);
  modport sink   (input valid, input kind, input side, input edge_index, input start_x,
                  input start_y, input end_x, input end_y, input overflow, input last,
                  output ready);
endinterface

// ===== sv/tile_grid_edge_extractor_top.sv =====
// Tile grid edge extractor: boundary edge updates from raster-order occupancy cells.
//
//   channel    dir   handshake          carries
//   cell_in    in    valid/ready        frame_start, here_on, east_on, south_on
//   edge_out   out   valid/ready        kind, side, edge_index, corners, overflow, last
//   cfg_*      in    cfg_we only        cfg_index, cfg_data (no read-back)
//
// The four-entry result bank is drained one transfer per cycle while edge_out is ready;
// a cell's results pass through the stage 1 registers and then the result bank.
// The line store is read when a cell is accepted and written back when it leaves stage 1.
// Reset clears counters, west marks, edge count and pipeline valids; line store is not cleared.
// A stalled edge_out holds the result bank; cell_in keeps accepting until stage 1 is full.
module tile_grid_edge_extractor_top #(
  parameter int MAX_COLUMNS     = 256,
  parameter int EDGE_INDEX_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  tge_cell_if.sink          cell_in,
  tge_edge_if.source        edge_out
);

  localparam int CB  = $clog2(MAX_COLUMNS);
  localparam int WW  = ($clog2(MAX_COLUMNS + 1) > 9) ? $clog2(MAX_COLUMNS + 1) : 9;
  localparam int EB  = EDGE_INDEX_BITS;
  localparam logic [EB-1:0] EdgeMax = '1;

  typedef struct packed {
    logic          on;
    logic          has_a;   // west cell: north side, cell above: west side
    logic          has_b;   // west cell: south side, cell above: east side
    logic [EB-1:0] id_a;
    logic [EB-1:0] id_b;
  } marks_t;

  // configuration
  logic [8:0] grid_width;
  logic [8:0] grid_height;
  logic [6:0] cell_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 9'd192;
      grid_height <= 9'd108;
      cell_size   <= 7'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        tge_pkg::RegGridWidth:  grid_width  <= cfg_data;
        tge_pkg::RegGridHeight: grid_height <= cfg_data;
        tge_pkg::RegCellSize:   cell_size   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] width_used;
  logic [8:0]    height_used;

  always_comb begin
    if (grid_width == '0)                       width_used = WW'(1);
    else if (WW'(grid_width) > WW'(MAX_COLUMNS)) width_used = WW'(MAX_COLUMNS);
    else                                         width_used = WW'(grid_width);
    if (grid_height == '0)         height_used = 9'd1;
    else if (grid_height > 9'd256) height_used = 9'd256;
    else                           height_used = grid_height;
  end

  // ---------------------------------------------------------------- accept side
  logic [CB-1:0] column;
  logic [7:0]    row;
  logic [CB-1:0] col_eff;
  logic [7:0]    row_eff;
  logic [WW-1:0] col_inc;
  logic [8:0]    row_inc;
  logic          last_col;
  logic          last_row;
  logic          accept;

  always_comb begin
    if (cell_in.frame_start || (WW'(column) >= width_used)) col_eff = '0;
    else                                                   col_eff = column;
    if (cell_in.frame_start || ({1'b0, row} >= height_used)) row_eff = '0;
    else                                                    row_eff = row;
    col_inc  = WW'(col_eff) + WW'(1);
    row_inc  = {1'b0, row_eff} + 9'd1;
    last_col = col_inc >= width_used;
    last_row = row_inc >= height_used;
  end

  assign accept = cell_in.valid && cell_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      column <= last_col ? '0 : col_inc[CB-1:0];
      if (last_col) row <= last_row ? 8'd0 : row_inc[7:0];
      else          row <= row_eff;
    end
  end

  // ---------------------------------------------------------------- stage 1 registers
  logic                          s1_valid;
  logic                          s1_adv;
  logic                          s1_fs;
  logic                          s1_here;
  logic                          s1_east;
  logic                          s1_south;
  logic [CB-1:0]                 s1_col;
  logic                          s1_row_nz;
  logic [tge_pkg::CoordBits-1:0] s1_x0, s1_x1, s1_y0, s1_y1;

  assign cell_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst)         s1_valid <= 1'b0;
    else if (accept) s1_valid <= 1'b1;
    else if (s1_adv) s1_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fs     <= cell_in.frame_start;
      s1_here   <= cell_in.here_on;
      s1_east   <= cell_in.east_on && !last_col;
      s1_south  <= cell_in.south_on && !last_row;
      s1_col    <= col_eff;
      s1_row_nz <= row_eff != 8'd0;
      s1_x0     <= tge_pkg::coord(13'(col_eff), cell_size);
      s1_x1     <= tge_pkg::coord(13'(col_inc), cell_size);
      s1_y0     <= tge_pkg::coord(13'(row_eff), cell_size);
      s1_y1     <= tge_pkg::coord(13'(row_inc), cell_size);
    end
  end

  // ---------------------------------------------------------------- line store
  marks_t line_mem [MAX_COLUMNS];
  marks_t rd_data;
  marks_t fwd_data;
  logic   fwd_hit;
  marks_t mine_a;
  marks_t mine_w;

  always_ff @(posedge clk) begin
    if (s1_adv) line_mem[s1_col] <= mine_a;
    if (accept) rd_data <= line_mem[col_eff];
  end

  // write-back and read of the same column on one edge (one-column grid)
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_hit  <= s1_adv && (s1_col == col_eff);
      fwd_data <= mine_a;
    end
  end

  // ---------------------------------------------------------------- stage 1 logic
  marks_t          west_marks;
  logic [EB-1:0]   edge_count;
  marks_t          wm;
  marks_t          above;
  logic [EB-1:0]   ec_in;
  logic [EB-1:0]   ec_out;
  logic            north_on, west_on;
  logic            need_n, need_w, need_s, need_e;
  logic            ext_n, ext_w, ext_s, ext_e;
  logic            new_n, new_w, new_s, new_e;
  logic [2:0]      nb_w, nb_s, nb_e, nnew;
  logic [EB-1:0]   id_n, id_w, id_s, id_e;
  logic            cell_ovf;
  logic            slot_act [4];
  tge_pkg::result_t slot_res [4];
  tge_pkg::result_t cmp_res [4];
  logic [2:0]      n_res;

  function automatic logic [EB-1:0] sat_add(input logic [EB-1:0] a, input logic [2:0] k);
    logic [EB:0] s;
    s       = {1'b0, a} + (EB+1)'(k);
    sat_add = (s > {1'b0, EdgeMax}) ? EdgeMax : s[EB-1:0];
  endfunction

  always_comb begin
    ec_in = s1_fs ? '0 : edge_count;
    wm    = s1_fs ? '0 : west_marks;
    above = s1_row_nz ? (fwd_hit ? fwd_data : rd_data) : '0;

    north_on = s1_row_nz && above.on;
    west_on  = (s1_col != '0) && wm.on;

    need_n = s1_here && !north_on;
    need_w = s1_here && !west_on;
    need_s = s1_here && !s1_south;
    need_e = s1_here && !s1_east;

    ext_n = west_on && wm.has_a;
    ext_w = north_on && above.has_a;
    ext_s = west_on && wm.has_b;
    ext_e = north_on && above.has_b;

    new_n = need_n && !ext_n;
    new_w = need_w && !ext_w;
    new_s = need_s && !ext_s;
    new_e = need_e && !ext_e;

    nb_w = {2'b0, new_n};
    nb_s = nb_w + {2'b0, new_w};
    nb_e = nb_s + {2'b0, new_s};
    nnew = nb_e + {2'b0, new_e};

    id_n = ext_n ? wm.id_a    : ec_in;
    id_w = ext_w ? above.id_a : sat_add(ec_in, nb_w);
    id_s = ext_s ? wm.id_b    : sat_add(ec_in, nb_s);
    id_e = ext_e ? above.id_b : sat_add(ec_in, nb_e);

    ec_out   = sat_add(ec_in, nnew);
    cell_ovf = ec_out == EdgeMax;

    mine_w = '{on: s1_here, has_a: need_n, has_b: need_s, id_a: id_n, id_b: id_s};
    mine_a = '{on: s1_here, has_a: need_w, has_b: need_e, id_a: id_w, id_b: id_e};

    // north
    slot_act[0] = need_n;
    slot_res[0].side       = tge_pkg::SideNorth;
    slot_res[0].kind       = ext_n ? tge_pkg::KindExtend : tge_pkg::KindNew;
    slot_res[0].edge_index = tge_pkg::IdOutBits'(id_n);
    slot_res[0].start_x    = ext_n ? '0 : s1_x0;
    slot_res[0].start_y    = ext_n ? '0 : s1_y0;
    slot_res[0].end_x      = s1_x1;
    slot_res[0].end_y      = s1_y0;
    // west
    slot_act[1] = need_w;
    slot_res[1].side       = tge_pkg::SideWest;
    slot_res[1].kind       = ext_w ? tge_pkg::KindExtend : tge_pkg::KindNew;
    slot_res[1].edge_index = tge_pkg::IdOutBits'(id_w);
    slot_res[1].start_x    = ext_w ? '0 : s1_x0;
    slot_res[1].start_y    = ext_w ? '0 : s1_y0;
    slot_res[1].end_x      = s1_x0;
    slot_res[1].end_y      = s1_y1;
    // south
    slot_act[2] = need_s;
    slot_res[2].side       = tge_pkg::SideSouth;
    slot_res[2].kind       = ext_s ? tge_pkg::KindExtend : tge_pkg::KindNew;
    slot_res[2].edge_index = tge_pkg::IdOutBits'(id_s);
    slot_res[2].start_x    = ext_s ? '0 : s1_x0;
    slot_res[2].start_y    = ext_s ? '0 : s1_y1;
    slot_res[2].end_x      = s1_x1;
    slot_res[2].end_y      = s1_y1;
    // east
    slot_act[3] = need_e;
    slot_res[3].side       = tge_pkg::SideEast;
    slot_res[3].kind       = ext_e ? tge_pkg::KindExtend : tge_pkg::KindNew;
    slot_res[3].edge_index = tge_pkg::IdOutBits'(id_e);
    slot_res[3].start_x    = ext_e ? '0 : s1_x1;
    slot_res[3].start_y    = ext_e ? '0 : s1_y0;
    slot_res[3].end_x      = s1_x1;
    slot_res[3].end_y      = s1_y1;

    // pack active slots in the order north, west, south, east
    n_res = 3'd0;
    for (int k = 0; k < 4; k++) cmp_res[k] = '0;
    for (int k = 0; k < 4; k++) begin
      if (slot_act[k]) begin
        cmp_res[n_res[1:0]] = slot_res[k];
        n_res = n_res + 3'd1;
      end
    end
  end

  // ---------------------------------------------------------------- result bank
  tge_pkg::result_t bank [4];
  logic [2:0]       bank_cnt;
  logic [1:0]       bank_ptr;
  logic             bank_ovf;
  logic             bank_valid;
  logic             bank_last;
  logic             out_xfer;
  logic             bank_free;

  assign bank_last = ({1'b0, bank_ptr} + 3'd1) == bank_cnt;
  assign out_xfer  = bank_valid && edge_out.ready;
  assign bank_free = !bank_valid || (out_xfer && bank_last);
  assign s1_adv    = s1_valid && ((n_res == 3'd0) || bank_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= 1'b0;
      bank_ptr   <= '0;
      west_marks <= '0;
      edge_count <= '0;
    end else begin
      // a new load wins over the drain of the last held result
      if (s1_adv && (n_res != 3'd0)) begin
        bank_valid <= 1'b1;
        bank_ptr   <= '0;
      end else if (out_xfer) begin
        if (bank_last) bank_valid <= 1'b0;
        else           bank_ptr   <= bank_ptr + 2'd1;
      end
      if (s1_adv) begin
        west_marks <= mine_w;
        edge_count <= ec_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (n_res != 3'd0)) begin
      bank     <= cmp_res;
      bank_cnt <= n_res;
      bank_ovf <= cell_ovf;
    end
  end

  assign edge_out.valid      = bank_valid;
  assign edge_out.kind       = bank[bank_ptr].kind;
  assign edge_out.side       = bank[bank_ptr].side;
  assign edge_out.edge_index = bank[bank_ptr].edge_index;
  assign edge_out.start_x    = bank[bank_ptr].start_x;
  assign edge_out.start_y    = bank[bank_ptr].start_y;
  assign edge_out.end_x      = bank[bank_ptr].end_x;
  assign edge_out.end_y      = bank[bank_ptr].end_y;
  assign edge_out.overflow   = bank_ovf;
  assign edge_out.last       = bank_last;

endmodule

// ===== sv/tge_checker.sv =====
// Port-level checks for the tile grid edge extractor, bound to the top level.
module tge_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_kind,
  input logic [tge_pkg::CoordBits-1:0] out_start_x,
  input logic [tge_pkg::CoordBits-1:0] out_start_y,
  input logic                          out_overflow,
  input logic                          out_last
);

  // a pending result is not withdrawn
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("edge_out valid dropped while stalled");

  // results of one cell come without gaps
  a_cell_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside the results of one cell");

  // overflow is a per-cell flag
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_overflow == $past(out_overflow))
    else $error("overflow changed inside one cell");

  // extensions carry no start corner
  a_ext_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == tge_pkg::KindExtend) |-> (out_start_x == '0) && (out_start_y == '0))
    else $error("extension with nonzero start corner");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tile_grid_edge_extractor_top tge_checker u_tge_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (edge_out.valid),
  .out_ready    (edge_out.ready),
  .out_kind     (edge_out.kind),
  .out_start_x  (edge_out.start_x),
  .out_start_y  (edge_out.start_y),
  .out_overflow (edge_out.overflow),
  .out_last     (edge_out.last)
);
